// ===== rtl/core/lzss_pkg.sv =====
// lzss_pkg: shared constants and types for the LZSS stream decompressor.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package lzss_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_phase;

    // Parse phases
    localparam t_phase PH_FLAG  = 2'd0;
    localparam t_phase PH_TOKEN = 2'd1;
    localparam t_phase PH_HIGH  = 2'd2;

    localparam int    START_POS  = 4078;
    localparam t_byte SPACE_CHAR = 8'h20;
    localparam int    MIN_LEN    = 3;

endpackage

`default_nettype wire

// ===== rtl/core/lzss_in_if.sv =====
// lzss_in_if: compressed byte channel, valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lzss_out_if.sv =====
// lzss_out_if: decompressed byte channel, valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lzss_ram.sv =====
// lzss_ram: generic single-write, single-read RAM with registered read data.
// Read-during-write to the same address returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/lzss_stream_decompressor.sv =====
// LZSS stream decompressor, 4 KiB history window. Depends on lzss_pkg, lzss_in_if,
// lzss_out_if and lzss_ram. A flag byte is taken on its own; a literal is taken, then
// written and sent out; a reference takes its low and high bytes, then copies one byte
// per cycle while the output is not stalled. No new input is taken until that is done.
// Reset (synchronous, active low) and every end-of-stream beat start a clearing
// pass over all WINDOW_DEPTH entries that fills the window with spaces; no input then.
`timescale 1ns / 1ps
`default_nettype none

module lzss_stream_decompressor #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lzss_in_if.sink          i_in,
    lzss_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    import lzss_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] L_START = AW'(START_POS % WINDOW_DEPTH);
    localparam logic [AW-1:0] L_LAST_ADDR = AW'(WINDOW_DEPTH - 1);

    // Sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;  // fill window with spaces
    localparam logic [1:0] S_IDLE  = 2'd1;  // take next compressed byte
    localparam logic [1:0] S_LIT   = 2'd2;  // push a literal out
    localparam logic [1:0] S_COPY  = 2'd3;  // back-reference copy, one byte a cycle unless the output stalls

    // Control state
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_wpos, n_wpos;
    t_phase        r_phase, n_phase;
    logic [2:0]    r_fidx, n_fidx;
    logic [31:0]   r_count, n_count;
    logic [31:0]   r_limit, n_limit;
    logic          r_eos, n_eos;
    logic [4:0]    r_rem, n_rem;
    logic          r_fwd, n_fwd;
    logic          r_out_valid, n_out_valid;

    // Payload
    t_byte         r_flags, n_flags;
    t_byte         r_ref_low, n_ref_low;
    t_byte         r_lit, n_lit;
    logic [AW-1:0] r_src, n_src;
    t_byte         r_fwd_data, n_fwd_data;
    t_byte         r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    // Window port
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_byte         mem_wdata, mem_rdata;

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic          in_acc;
    logic          can_load;     // output register free this cycle
    logic          below_limit;
    logic          copy_last;
    t_byte         copy_data;    // forwarded when the read hit the entry being written
    logic [AW-1:0] ref_src;
    logic [4:0]    ref_len;
    logic          tok_lit;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign can_load    = !r_out_valid || o_out.ready;
    assign below_limit = (r_count < r_limit);
    assign copy_last   = (r_rem == 5'd1) || ((33'(r_count) + 33'd1) >= {1'b0, r_limit});
    assign copy_data   = r_fwd ? r_fwd_data : mem_rdata;
    assign ref_src     = AW'({i_in.in_byte[7:4], r_ref_low});
    assign ref_len     = {1'b0, i_in.in_byte[3:0]} + 5'(MIN_LEN);
    assign tok_lit     = r_flags[r_fidx];

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_wpos      = r_wpos;
        n_phase     = r_phase;
        n_fidx      = r_fidx;
        n_count     = r_count;
        n_limit     = i_cfg_we ? i_cfg_wdata : r_limit;
        n_eos       = r_eos;
        n_rem       = r_rem;
        n_fwd       = r_fwd;
        n_out_valid = r_out_valid;
        n_flags     = r_flags;
        n_ref_low   = r_ref_low;
        n_lit       = r_lit;
        n_src       = r_src;
        n_fwd_data  = r_fwd_data;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_wpos;
        mem_wdata   = r_lit;
        mem_re      = 1'b0;
        mem_raddr   = r_src;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Stream state back to its start values while sweeping.
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = SPACE_CHAR;
                n_clr_addr = r_clr_addr + 1'b1;
                n_wpos     = L_START;
                n_phase    = PH_FLAG;
                n_fidx     = 3'd0;
                n_flags    = 8'h00;
                n_count    = 32'd0;
                n_eos      = 1'b0;
                if (r_clr_addr == L_LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_eos = i_in.end_of_stream;
                    case (r_phase)
                        PH_TOKEN: begin
                            if (tok_lit) begin
                                n_lit = i_in.in_byte;
                                if (below_limit) begin
                                    n_state = S_LIT;
                                end else begin
                                    // suppressed literal: token ends here
                                    n_fidx  = r_fidx + 3'd1;
                                    n_phase = (r_fidx == 3'd7) ? PH_FLAG : PH_TOKEN;
                                    if (i_in.end_of_stream) begin
                                        n_state = S_CLEAR;
                                    end
                                end
                            end else begin
                                // reference low byte; a cut-off one just restarts
                                n_ref_low = i_in.in_byte;
                                n_phase   = PH_HIGH;
                                if (i_in.end_of_stream) begin
                                    n_state = S_CLEAR;
                                end
                            end
                        end
                        PH_HIGH: begin
                            if (below_limit) begin
                                mem_re    = 1'b1;
                                mem_raddr = ref_src;
                                n_src     = ref_src + 1'b1;
                                n_rem     = ref_len;
                                n_fwd     = 1'b0;
                                n_state   = S_COPY;
                            end else begin
                                n_fidx  = r_fidx + 3'd1;
                                n_phase = (r_fidx == 3'd7) ? PH_FLAG : PH_TOKEN;
                                if (i_in.end_of_stream) begin
                                    n_state = S_CLEAR;
                                end
                            end
                        end
                        default: begin
                            n_flags = i_in.in_byte;
                            n_fidx  = 3'd0;
                            n_phase = PH_TOKEN;
                            if (i_in.end_of_stream) begin
                                n_state = S_CLEAR;
                            end
                        end
                    endcase
                end
            end
            S_LIT: begin
                if (can_load) begin
                    mem_we      = 1'b1;
                    mem_wdata   = r_lit;
                    n_wpos      = r_wpos + 1'b1;
                    n_count     = r_count + 32'd1;
                    n_out_valid = 1'b1;
                    n_out_byte  = r_lit;
                    n_out_last  = 1'b1;
                    n_fidx      = r_fidx + 3'd1;
                    n_phase     = (r_fidx == 3'd7) ? PH_FLAG : PH_TOKEN;
                    n_state     = r_eos ? S_CLEAR : S_IDLE;
                end
            end
            default: begin  // S_COPY
                if (can_load) begin
                    mem_we      = 1'b1;
                    mem_wdata   = copy_data;
                    n_wpos      = r_wpos + 1'b1;
                    n_count     = r_count + 32'd1;
                    n_rem       = r_rem - 5'd1;
                    n_out_valid = 1'b1;
                    n_out_byte  = copy_data;
                    n_out_last  = copy_last;
                    if (copy_last) begin
                        n_fidx  = r_fidx + 3'd1;
                        n_phase = (r_fidx == 3'd7) ? PH_FLAG : PH_TOKEN;
                        n_state = r_eos ? S_CLEAR : S_IDLE;
                    end else begin
                        // next source read; same entry as this write -> forward
                        mem_re     = 1'b1;
                        mem_raddr  = r_src;
                        n_src      = r_src + 1'b1;
                        n_fwd      = (r_src == r_wpos);
                        n_fwd_data = copy_data;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wpos      <= L_START;
            r_phase     <= PH_FLAG;
            r_fidx      <= 3'd0;
            r_count     <= 32'd0;
            r_limit     <= 32'hFFFF_FFFF;
            r_eos       <= 1'b0;
            r_rem       <= 5'd0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_wpos      <= n_wpos;
            r_phase     <= n_phase;
            r_fidx      <= n_fidx;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_eos       <= n_eos;
            r_rem       <= n_rem;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags    <= n_flags;
        r_ref_low  <= n_ref_low;
        r_lit      <= n_lit;
        r_src      <= n_src;
        r_fwd_data <= n_fwd_data;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

// ===== rtl/core/lzss_checker.sv =====
// lzss_checker: port-level assertions for the LZSS stream decompressor.
// Bound to lzss_stream_decompressor; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lzss_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_eos,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // Reset always starts a window clear, so no input beat right after it.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // End of stream starts a window clear.
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_eos |=> !i_in_ready)
        else $error("input ready right after end-of-stream beat");

    // Stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("stalled output beat changed");

endmodule

bind lzss_stream_decompressor lzss_checker u_lzss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_eos    (i_in.end_of_stream),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.run_last)
);

`default_nettype wire
